// File: sv/thick_segment_quad_expand_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thick segment quad expander
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef THICK_SEGMENT_QUAD_EXPAND_ASSERT_SVH
`define THICK_SEGMENT_QUAD_EXPAND_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define TSQ_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsq: assertion failed");
// next-cycle implication
`define TSQ_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsq: assertion failed");
`else
`define TSQ_ASSERT_IMP(name, ante, cons)
`define TSQ_ASSERT_NXT(name, ante, cons)
`endif

`endif

// File: sv/tsq_pkg.sv
// ----------------------------------------------------------------------------
// tsq_pkg
// Widths, constants and request/result types of the thick segment expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tsq_pkg;

  localparam int CW  = 32;            // coordinate width
  localparam int UW  = 30;            // fraction bits of the unit vector
  localparam int LW  = CW - 1;        // thickness, normalized delta, length, unit
  localparam int SQW = 2 * LW;        // sum of squares / products
  localparam int QW  = LW + 1;        // quotient bits produced by the divider
  localparam int NW  = LW + UW;       // dividend width
  localparam int OW  = CW + 3;        // offset and corner sum width
  localparam int PW  = $clog2(CW);    // bit index width

  localparam int               NUM_CORNERS = 4;
  localparam int               CK_W        = $clog2(NUM_CORNERS);
  localparam logic [CK_W-1:0]  LAST_K      = CK_W'(NUM_CORNERS - 1);
  localparam logic [CW-1:0]    UNIT_ONE    = CW'(1) << UW;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic [CW-2:0]        thickness;
    logic                 end_cap;
  } tsq_in_t;

  typedef struct packed {
    logic signed [CW-1:0] corner_x;
    logic signed [CW-1:0] corner_y;
    logic signed [CW-1:0] box_min_x;
    logic signed [CW-1:0] box_max_x;
    logic signed [CW-1:0] box_min_y;
    logic signed [CW-1:0] box_max_y;
    logic                 degenerate;
    logic                 last_corner;
  } tsq_out_t;

  // request fields carried alongside the arithmetic
  typedef struct packed {
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [CW-1:0] ex;
    logic signed [CW-1:0] ey;
    logic [CW-2:0]        th;
    logic                 cap;
    logic                 nx;
    logic                 ny;
    logic                 degen;
  } tsq_side_t;

  // finished quad: four corners and box
  typedef struct packed {
    logic [NUM_CORNERS-1:0][CW-1:0] cx;
    logic [NUM_CORNERS-1:0][CW-1:0] cy;
    logic [CW-1:0]                  min_x;
    logic [CW-1:0]                  max_x;
    logic [CW-1:0]                  min_y;
    logic [CW-1:0]                  max_y;
    logic                           degen;
  } tsq_fin_t;

endpackage

`default_nettype wire

// File: sv/tsq_front.sv
// ----------------------------------------------------------------------------
// tsq_front
// Delta, normalizing shift and sum of squares, four stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_front import tsq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsq_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tsq_side_t        out_side,
  output logic [LW-1:0]    out_ax,
  output logic [LW-1:0]    out_ay,
  output logic [SQW-1:0]   out_sum
);

  localparam int NS = 4;

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  // stage 1: sign and magnitude of the delta
  logic          nx_w, ny_w;
  logic [CW:0]   dx_w, dy_w;
  tsq_side_t     side1_nxt, side1_r, side2_r, side3_r, side4_r;
  logic [CW-1:0] ax1_r, ay1_r;

  always_comb begin
    nx_w = in_data.end_x < in_data.start_x;
    ny_w = in_data.end_y < in_data.start_y;
    dx_w = nx_w ? {in_data.start_x[CW-1], in_data.start_x} - {in_data.end_x[CW-1], in_data.end_x}
                : {in_data.end_x[CW-1], in_data.end_x} - {in_data.start_x[CW-1], in_data.start_x};
    dy_w = ny_w ? {in_data.start_y[CW-1], in_data.start_y} - {in_data.end_y[CW-1], in_data.end_y}
                : {in_data.end_y[CW-1], in_data.end_y} - {in_data.start_y[CW-1], in_data.start_y};
    side1_nxt.sx    = in_data.start_x;
    side1_nxt.sy    = in_data.start_y;
    side1_nxt.ex    = in_data.end_x;
    side1_nxt.ey    = in_data.end_y;
    side1_nxt.th    = in_data.thickness;
    side1_nxt.cap   = in_data.end_cap;
    side1_nxt.nx    = nx_w;
    side1_nxt.ny    = ny_w;
    side1_nxt.degen = (dx_w[CW-1:0] == '0) && (dy_w[CW-1:0] == '0);
  end

  // stage 2: shift the larger magnitude into [2^(UW-1), 2^UW]
  logic [CW-1:0] mx_w;
  logic [PW-1:0] msb_w, shl_w;
  logic [LW-1:0] ax2_nxt, ay2_nxt, ax2_r, ay2_r, ax3_r, ay3_r, ax4_r, ay4_r;

  always_comb begin
    mx_w  = (ax1_r > ay1_r) ? ax1_r : ay1_r;
    msb_w = '0;
    for (int b = 0; b < CW; b++) if (mx_w[b]) msb_w = PW'(b);
    shl_w = (msb_w < PW'(UW - 1)) ? PW'(UW - 1) - msb_w : '0;
    if (mx_w > UNIT_ONE) begin
      // magnitudes stay below 2^CW, so two right steps at most
      if ((mx_w >> 1) > UNIT_ONE) begin
        ax2_nxt = LW'(ax1_r >> 2);
        ay2_nxt = LW'(ay1_r >> 2);
      end else begin
        ax2_nxt = LW'(ax1_r >> 1);
        ay2_nxt = LW'(ay1_r >> 1);
      end
    end else begin
      ax2_nxt = LW'(ax1_r << shl_w);
      ay2_nxt = LW'(ay1_r << shl_w);
    end
  end

  // stage 3: squares, stage 4: sum
  logic [SQW-1:0] sqx_w, sqy_w, sqx_r, sqy_r, sum_r;

  assign sqx_w = ax2_r * ax2_r;
  assign sqy_w = ay2_r * ay2_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side1_r <= side1_nxt;
      ax1_r   <= dx_w[CW-1:0];
      ay1_r   <= dy_w[CW-1:0];
    end
    if (en[1]) begin
      side2_r <= side1_r;
      ax2_r   <= ax2_nxt;
      ay2_r   <= ay2_nxt;
    end
    if (en[2]) begin
      side3_r <= side2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      sqx_r   <= sqx_w;
      sqy_r   <= sqy_w;
    end
    if (en[3]) begin
      side4_r <= side3_r;
      ax4_r   <= ax3_r;
      ay4_r   <= ay3_r;
      sum_r   <= sqx_r + sqy_r;
    end
  end

  assign out_side = side4_r;
  assign out_ax   = ax4_r;
  assign out_ay   = ay4_r;
  assign out_sum  = sum_r;

endmodule

`default_nettype wire

// File: sv/tsq_sqrt.sv
// ----------------------------------------------------------------------------
// tsq_sqrt
// Integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_sqrt import tsq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsq_side_t        in_side,
  input  logic [LW-1:0]    in_ax,
  input  logic [LW-1:0]    in_ay,
  input  logic [SQW-1:0]   in_sum,
  output logic             out_valid,
  input  logic             out_ready,
  output tsq_side_t        out_side,
  output logic [LW-1:0]    out_ax,
  output logic [LW-1:0]    out_ay,
  output logic [LW-1:0]    out_len
);

  localparam int NS = SQW / 2;
  localparam int RW = SQW + 1;

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  logic [SQW-1:0] rem_r  [NS];
  logic [RW-1:0]  res_r  [NS];
  logic [LW-1:0]  ax_r   [NS];
  logic [LW-1:0]  ay_r   [NS];
  tsq_side_t      side_r [NS];

  for (genvar j = 0; j < NS; j++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (SQW - 2 - 2 * j);

    logic [SQW-1:0] rem_i, rem_nxt;
    logic [RW-1:0]  res_i, res_nxt, trial;
    logic [LW-1:0]  ax_i, ay_i;
    tsq_side_t      side_i;

    if (j == 0) begin : g_head
      assign rem_i  = in_sum;
      assign res_i  = '0;
      assign ax_i   = in_ax;
      assign ay_i   = in_ay;
      assign side_i = in_side;
    end else begin : g_body
      assign rem_i  = rem_r[j-1];
      assign res_i  = res_r[j-1];
      assign ax_i   = ax_r[j-1];
      assign ay_i   = ay_r[j-1];
      assign side_i = side_r[j-1];
    end

    assign trial = res_i + BIT;

    always_comb begin
      if (RW'(rem_i) >= trial) begin
        rem_nxt = rem_i - trial[SQW-1:0];
        res_nxt = (res_i >> 1) + BIT;
      end else begin
        rem_nxt = rem_i;
        res_nxt = res_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j]  <= rem_nxt;
        res_r[j]  <= res_nxt;
        ax_r[j]   <= ax_i;
        ay_r[j]   <= ay_i;
        side_r[j] <= side_i;
      end
    end
  end

  assign out_side = side_r[NS-1];
  assign out_ax   = ax_r[NS-1];
  assign out_ay   = ay_r[NS-1];
  assign out_len  = res_r[NS-1][LW-1:0];

endmodule

`default_nettype wire

// File: sv/tsq_div.sv
// ----------------------------------------------------------------------------
// tsq_div
// Rounded unit vector: two restoring dividers, one quotient bit per stage after stage 0.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_div import tsq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsq_side_t        in_side,
  input  logic [LW-1:0]    in_ax,
  input  logic [LW-1:0]    in_ay,
  input  logic [LW-1:0]    in_len,
  output logic             out_valid,
  input  logic             out_ready,
  output tsq_side_t        out_side,
  output logic [LW-1:0]    out_ux,
  output logic [LW-1:0]    out_uy
);

  localparam int NS = QW + 1;

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  logic [1:0][LW-1:0] rem_r  [NS];
  logic [1:0][QW-1:0] low_r  [NS];
  logic [1:0][QW-1:0] q_r    [NS];
  logic [LW-1:0]      len_r  [NS];
  tsq_side_t          side_r [NS];

  // stage 0: dividend with half the divisor added for rounding
  logic [1:0][NW-1:0] num_w;
  logic [1:0][LW-1:0] num_a;

  assign num_a[0] = in_ax;
  assign num_a[1] = in_ay;

  always_comb begin
    for (int c = 0; c < 2; c++) begin
      num_w[c] = {num_a[c], UW'(0)} + NW'(in_len >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int c = 0; c < 2; c++) begin
        rem_r[0][c] <= LW'(num_w[c][NW-1:QW]);
        low_r[0][c] <= num_w[c][QW-1:0];
        q_r[0][c]   <= '0;
      end
      len_r[0]  <= in_len;
      side_r[0] <= in_side;
    end
  end

  for (genvar j = 1; j < NS; j++) begin : g_step
    logic [1:0][LW-1:0] rem_nxt;
    logic [1:0][QW-1:0] q_nxt;
    logic [1:0][LW:0]   sh_w;

    always_comb begin
      for (int c = 0; c < 2; c++) begin
        sh_w[c] = {rem_r[j-1][c], low_r[j-1][c][QW-1]};
        if (sh_w[c] >= {1'b0, len_r[j-1]}) begin
          rem_nxt[c] = LW'(sh_w[c] - {1'b0, len_r[j-1]});
          q_nxt[c]   = {q_r[j-1][c][QW-2:0], 1'b1};
        end else begin
          rem_nxt[c] = sh_w[c][LW-1:0];
          q_nxt[c]   = {q_r[j-1][c][QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rem_r[j] <= rem_nxt;
        q_r[j]   <= q_nxt;
        for (int c = 0; c < 2; c++) low_r[j][c] <= low_r[j-1][c] << 1;
        len_r[j]  <= len_r[j-1];
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_side = side_r[NS-1];
  assign out_ux   = q_r[NS-1][0][LW-1:0];
  assign out_uy   = q_r[NS-1][1][LW-1:0];

endmodule

`default_nettype wire

// File: sv/tsq_back.sv
// ----------------------------------------------------------------------------
// tsq_back
// Scale by half thickness, build and saturate corners, bounding box.
// ----------------------------------------------------------------------------
`default_nettype none

module tsq_back import tsq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsq_side_t        in_side,
  input  logic [LW-1:0]    in_ux,
  input  logic [LW-1:0]    in_uy,
  output logic             out_valid,
  input  logic             out_ready,
  output tsq_fin_t         out_fin
);

  localparam int NS = 6;
  localparam logic [SQW-1:0]      RND  = SQW'(1) << UW;
  localparam logic signed [OW-1:0] CMAX = (OW'(1) << (CW - 1)) - OW'(1);
  localparam logic signed [OW-1:0] CMIN = ~CMAX;

  function automatic logic [CW-1:0] sat_f(input logic signed [OW-1:0] v);
    logic [CW-1:0] r;
    if (v > CMAX)      r = CMAX[CW-1:0];
    else if (v < CMIN) r = CMIN[CW-1:0];
    else               r = v[CW-1:0];
    return r;
  endfunction

  function automatic logic signed [OW-1:0] sext_f(input logic [CW-1:0] v);
    return $signed({{(OW - CW){v[CW-1]}}, v});
  endfunction

  logic [NS-1:0] v_r, en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) en[i] = !v_r[i] || en[i+1];
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) if (en[i]) v_r[i] <= v_r[i-1];
    end
  end

  tsq_side_t side1_r, side2_r, side3_r;

  // stage 1: thickness times unit component
  logic [SQW-1:0] px_w, py_w, px_r, py_r;
  assign px_w = in_side.th * in_ux;
  assign py_w = in_side.th * in_uy;

  // stage 2: round, apply direction sign
  logic [SQW-1:0]         prx_w, pry_w;
  logic signed [OW-1:0]   tx_nxt, ty_nxt, tx_r, ty_r;

  always_comb begin
    prx_w  = px_r + RND;
    pry_w  = py_r + RND;
    tx_nxt = $signed({(OW - LW)'(0), prx_w[SQW-1:UW+1]});
    ty_nxt = $signed({(OW - LW)'(0), pry_w[SQW-1:UW+1]});
    if (side1_r.nx) tx_nxt = -tx_nxt;
    if (side1_r.ny) ty_nxt = -ty_nxt;
  end

  // stage 3: corner offsets, tangent part only with end caps
  logic signed [OW-1:0]            axo_w, ayo_w;
  logic [NUM_CORNERS-1:0][OW-1:0]  ox_nxt, oy_nxt, ox_r, oy_r;

  always_comb begin
    axo_w     = side2_r.cap ? tx_r : '0;
    ayo_w     = side2_r.cap ? ty_r : '0;
    ox_nxt[0] = -axo_w + ty_r;
    oy_nxt[0] = -ayo_w - tx_r;
    ox_nxt[1] =  axo_w + ty_r;
    oy_nxt[1] =  ayo_w - tx_r;
    ox_nxt[2] =  axo_w - ty_r;
    oy_nxt[2] =  ayo_w + tx_r;
    ox_nxt[3] = -axo_w - ty_r;
    oy_nxt[3] = -ayo_w + tx_r;
  end

  // stage 4: add to endpoint and saturate; coincident endpoints give the start
  logic [NUM_CORNERS-1:0][CW-1:0] cx_nxt, cy_nxt, cx4_r, cy4_r, cx5_r, cy5_r, cx6_r, cy6_r;
  logic [CW-1:0]                  bx_w, by_w;
  logic                           degen4_r, degen5_r, degen6_r;

  always_comb begin
    for (int k = 0; k < NUM_CORNERS; k++) begin
      bx_w = (k == 0 || k == NUM_CORNERS - 1) ? side3_r.sx : side3_r.ex;
      by_w = (k == 0 || k == NUM_CORNERS - 1) ? side3_r.sy : side3_r.ey;
      if (side3_r.degen) begin
        cx_nxt[k] = side3_r.sx;
        cy_nxt[k] = side3_r.sy;
      end else begin
        cx_nxt[k] = sat_f(sext_f(bx_w) + $signed(ox_r[k]));
        cy_nxt[k] = sat_f(sext_f(by_w) + $signed(oy_r[k]));
      end
    end
  end

  // stage 5: pairwise min/max, stage 6: final box
  logic [1:0][CW-1:0] mnx_nxt, mxx_nxt, mny_nxt, mxy_nxt, mnx_r, mxx_r, mny_r, mxy_r;
  logic [CW-1:0]      bmnx_nxt, bmxx_nxt, bmny_nxt, bmxy_nxt;
  logic [CW-1:0]      bmnx_r, bmxx_r, bmny_r, bmxy_r;

  always_comb begin
    for (int p = 0; p < 2; p++) begin
      if ($signed(cx4_r[2*p]) < $signed(cx4_r[2*p+1])) begin
        mnx_nxt[p] = cx4_r[2*p];
        mxx_nxt[p] = cx4_r[2*p+1];
      end else begin
        mnx_nxt[p] = cx4_r[2*p+1];
        mxx_nxt[p] = cx4_r[2*p];
      end
      if ($signed(cy4_r[2*p]) < $signed(cy4_r[2*p+1])) begin
        mny_nxt[p] = cy4_r[2*p];
        mxy_nxt[p] = cy4_r[2*p+1];
      end else begin
        mny_nxt[p] = cy4_r[2*p+1];
        mxy_nxt[p] = cy4_r[2*p];
      end
    end
    bmnx_nxt = ($signed(mnx_r[0]) < $signed(mnx_r[1])) ? mnx_r[0] : mnx_r[1];
    bmxx_nxt = ($signed(mxx_r[0]) > $signed(mxx_r[1])) ? mxx_r[0] : mxx_r[1];
    bmny_nxt = ($signed(mny_r[0]) < $signed(mny_r[1])) ? mny_r[0] : mny_r[1];
    bmxy_nxt = ($signed(mxy_r[0]) > $signed(mxy_r[1])) ? mxy_r[0] : mxy_r[1];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side1_r <= in_side;
      px_r    <= px_w;
      py_r    <= py_w;
    end
    if (en[1]) begin
      side2_r <= side1_r;
      tx_r    <= tx_nxt;
      ty_r    <= ty_nxt;
    end
    if (en[2]) begin
      side3_r <= side2_r;
      ox_r    <= ox_nxt;
      oy_r    <= oy_nxt;
    end
    if (en[3]) begin
      cx4_r    <= cx_nxt;
      cy4_r    <= cy_nxt;
      degen4_r <= side3_r.degen;
    end
    if (en[4]) begin
      cx5_r    <= cx4_r;
      cy5_r    <= cy4_r;
      degen5_r <= degen4_r;
      mnx_r    <= mnx_nxt;
      mxx_r    <= mxx_nxt;
      mny_r    <= mny_nxt;
      mxy_r    <= mxy_nxt;
    end
    if (en[5]) begin
      cx6_r    <= cx5_r;
      cy6_r    <= cy5_r;
      degen6_r <= degen5_r;
      bmnx_r   <= bmnx_nxt;
      bmxx_r   <= bmxx_nxt;
      bmny_r   <= bmny_nxt;
      bmxy_r   <= bmxy_nxt;
    end
  end

  always_comb begin
    out_fin.cx    = cx6_r;
    out_fin.cy    = cy6_r;
    out_fin.min_x = bmnx_r;
    out_fin.max_x = bmxx_r;
    out_fin.min_y = bmny_r;
    out_fin.max_y = bmxy_r;
    out_fin.degen = degen6_r;
  end

endmodule

`default_nettype wire

// File: sv/thick_segment_quad_expand.sv
// ----------------------------------------------------------------------------
// thick_segment_quad_expand
// Expands a thick line segment into the four corners of its rectangle.
//
//   channel   dir   handshake              payload
//   in_       in    in_valid / in_ready    tsq_in_t  (endpoints, thickness, cap)
//   out_      out   out_valid / out_ready  tsq_out_t (one corner; box on last)
//
// Each request yields four results, corner 0 to 3, through the single result
// port, which sets the request rate; the next quad loads as the last corner
// of the one before leaves. To reach its first corner a request passes 4 front
// stages, 31 square-root stages, 33 divider stages, 6 scaling/corner/box
// stages and the output register. Every stage holds when the stage after it
// is full and stalled; empty stages fill up behind a stall, so nothing is
// lost or repeated. Reset clears only the valid bits and the corner counter.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thick_segment_quad_expand_assert.svh"

module thick_segment_quad_expand import tsq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tsq_in_t   in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output tsq_out_t  out_data
);

  // front: delta magnitudes, normalization, sum of squares
  logic           fr_valid, fr_ready;
  tsq_side_t      fr_side;
  logic [LW-1:0]  fr_ax, fr_ay;
  logic [SQW-1:0] fr_sum;

  tsq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_side  (fr_side),
    .out_ax    (fr_ax),
    .out_ay    (fr_ay),
    .out_sum   (fr_sum)
  );

  // segment length
  logic           sq_valid, sq_ready;
  tsq_side_t      sq_side;
  logic [LW-1:0]  sq_ax, sq_ay, sq_len;

  tsq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_side   (fr_side),
    .in_ax     (fr_ax),
    .in_ay     (fr_ay),
    .in_sum    (fr_sum),
    .out_valid (sq_valid),
    .out_ready (sq_ready),
    .out_side  (sq_side),
    .out_ax    (sq_ax),
    .out_ay    (sq_ay),
    .out_len   (sq_len)
  );

  // unit vector in Q30
  logic           dv_valid, dv_ready;
  tsq_side_t      dv_side;
  logic [LW-1:0]  dv_ux, dv_uy;

  tsq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_ready  (sq_ready),
    .in_side   (sq_side),
    .in_ax     (sq_ax),
    .in_ay     (sq_ay),
    .in_len    (sq_len),
    .out_valid (dv_valid),
    .out_ready (dv_ready),
    .out_side  (dv_side),
    .out_ux    (dv_ux),
    .out_uy    (dv_uy)
  );

  // offsets, corners, box
  logic      bk_valid, bk_ready;
  tsq_fin_t  bk_fin;

  tsq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_ready  (dv_ready),
    .in_side   (dv_side),
    .in_ux     (dv_ux),
    .in_uy     (dv_uy),
    .out_valid (bk_valid),
    .out_ready (bk_ready),
    .out_fin   (bk_fin)
  );

  // output register: hold one finished quad and walk its corners
  tsq_fin_t        fin_r;
  logic            fin_v_r;
  logic [CK_W-1:0] k_r;
  logic            last_w;

  assign last_w   = (k_r == LAST_K);
  // take the next quad when empty or as the last corner leaves
  assign bk_ready = !fin_v_r || (out_ready && last_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
      k_r     <= '0;
    end else if (bk_ready) begin
      fin_v_r <= bk_valid;
      k_r     <= '0;
    end else if (out_ready) begin
      // advance to the next corner
      k_r <= k_r + CK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (bk_ready) fin_r <= bk_fin;
  end

  assign out_valid = fin_v_r;

  always_comb begin
    out_data.corner_x    = fin_r.cx[k_r];
    out_data.corner_y    = fin_r.cy[k_r];
    // box only on the last corner, zero before it
    out_data.box_min_x   = last_w ? fin_r.min_x : '0;
    out_data.box_max_x   = last_w ? fin_r.max_x : '0;
    out_data.box_min_y   = last_w ? fin_r.min_y : '0;
    out_data.box_max_y   = last_w ? fin_r.max_y : '0;
    out_data.degenerate  = fin_r.degen;
    out_data.last_corner = last_w;
  end

  // box ordering on the last corner
  `TSQ_ASSERT_IMP(a_box_order, out_valid && out_data.last_corner, (out_data.box_min_x <= out_data.box_max_x) && (out_data.box_min_y <= out_data.box_max_y))
  // the last corner lies within the box
  `TSQ_ASSERT_IMP(a_last_in_box, out_valid && out_data.last_corner, (out_data.corner_x >= out_data.box_min_x) && (out_data.corner_x <= out_data.box_max_x) && (out_data.corner_y >= out_data.box_min_y) && (out_data.corner_y <= out_data.box_max_y))
  // a degenerate quad collapses to one point: box min x and max y match the last corner
  `TSQ_ASSERT_IMP(a_degen_point, out_valid && out_data.last_corner && out_data.degenerate, (out_data.box_min_x == out_data.corner_x) && (out_data.box_max_y == out_data.corner_y))
  // remaining corners of a quad follow without a gap
  `TSQ_ASSERT_NXT(a_corner_run, out_valid && out_ready && !out_data.last_corner, out_valid)

endmodule

`default_nettype wire
